// ===== rtl/core/fpm_pkg.sv =====
package fpm_pkg;

   // Operand and result layout: Q64.192 two's complement, 256 bits
   localparam int WORD_W      = 256;
   localparam int REQ_DATA_W  = 2 * WORD_W;

   // Limb split of each magnitude
   localparam int LIMB_W      = 16;
   localparam int NUM_LIMBS   = WORD_W / LIMB_W;
   localparam int PP_W        = 2 * LIMB_W;

   // Partial-product columns kept: limb index sum 10 to 27
   localparam int COL_FIRST   = 10;
   localparam int COL_LAST    = 27;
   localparam int NUM_COLS    = COL_LAST - COL_FIRST + 1;
   localparam int ROUND_COLS  = 2;
   localparam int COL_W       = PP_W + 4;
   localparam int COL_HI_W    = COL_W - LIMB_W;
   localparam int COL_TOP_W   = COL_W - 2 * LIMB_W;

   // Column reduction tree: four groups of four products
   localparam int GRP_SIZE    = 4;
   localparam int NUM_GRPS    = NUM_LIMBS / GRP_SIZE;
   localparam int GRP_W       = PP_W + 2;

   // Rounding on bit 15 of the two lowest kept columns
   localparam int RND_BIT     = LIMB_W - 1;
   localparam int RND_W       = COL_W + 1 - LIMB_W;

   // Register stages from request to result
   localparam int PIPE_DEPTH  = 8;
   localparam int DEPTH_W     = $clog2(PIPE_DEPTH + 1);

   typedef logic [WORD_W-1:0]                           word_type;
   typedef logic [NUM_COLS-1:0][COL_W-1:0]              col_vec_type;

   function automatic word_type neg_word(input word_type w);
      return ~w + WORD_W'(1);
   endfunction

endpackage

// ===== rtl/core/fpm_mag.sv =====
module fpm_mag (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_square,
   input  fpm_pkg::word_type in_a,
   input  fpm_pkg::word_type in_b,
   output logic              out_valid,
   input  logic              out_ready,
   output fpm_pkg::word_type out_mag_a,
   output fpm_pkg::word_type out_mag_b,
   output logic              out_neg
);
   import fpm_pkg::*;

   logic     v1_ff, v2_ff;
   logic     adv1, adv2;
   word_type a_ff, b_ff;
   word_type mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic     neg_ff, neg_in;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   // Squaring takes a in place of b
   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         a_ff <= in_a;
         b_ff <= in_square ? in_a : in_b;
      end
   end

   // Most negative value wraps to itself and reads as 2^255 unsigned
   always_comb begin
      mag_a_in = a_ff[WORD_W-1] ? neg_word(a_ff) : a_ff;
      mag_b_in = b_ff[WORD_W-1] ? neg_word(b_ff) : b_ff;
      neg_in   = a_ff[WORD_W-1] ^ b_ff[WORD_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         neg_ff   <= neg_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_mag_a = mag_a_ff;
   assign out_mag_b = mag_b_ff;
   assign out_neg   = neg_ff;

endmodule

// ===== rtl/core/fpm_ppgen.sv =====
module fpm_ppgen (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  fpm_pkg::word_type    in_mag_a,
   input  fpm_pkg::word_type    in_mag_b,
   input  logic                 in_neg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fpm_pkg::col_vec_type out_cols,
   output logic                 out_neg
);
   import fpm_pkg::*;

   logic v3_ff, v4_ff, v5_ff;
   logic adv3, adv4, adv5;

   logic [NUM_LIMBS-1:0][NUM_LIMBS-1:0][PP_W-1:0] pp_ff, pp_in;
   logic [NUM_COLS-1:0][NUM_GRPS-1:0][GRP_W-1:0]  grp_ff, grp_in;
   col_vec_type                                   col_ff, col_in;
   logic                                          neg3_ff, neg4_ff, neg5_ff;

   assign adv5     = !v5_ff || out_ready;
   assign adv4     = !v4_ff || adv5;
   assign adv3     = !v3_ff || adv4;
   assign in_ready = adv3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv3) v3_ff <= in_valid;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // Form only the products that land in a kept column
   always_comb begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
         for (int j = 0; j < NUM_LIMBS; j++) begin
            if (i + j >= COL_FIRST && i + j <= COL_LAST) begin
               pp_in[i][j] = PP_W'(in_mag_a[LIMB_W*i +: LIMB_W])
                           * PP_W'(in_mag_b[LIMB_W*j +: LIMB_W]);
            end else begin
               pp_in[i][j] = '0;
            end
         end
      end
   end

   // First tree level: sum each column in groups of four rows
   always_comb begin
      int i;
      int j;
      grp_in = '0;
      for (int k = 0; k < NUM_COLS; k++) begin
         for (int g = 0; g < NUM_GRPS; g++) begin
            for (int t = 0; t < GRP_SIZE; t++) begin
               i = g * GRP_SIZE + t;
               j = k + COL_FIRST - i;
               if (j >= 0 && j < NUM_LIMBS) begin
                  grp_in[k][g] = grp_in[k][g] + GRP_W'(pp_ff[i][j]);
               end
            end
         end
      end
   end

   // Second tree level: whole column sums
   always_comb begin
      col_in = '0;
      for (int k = 0; k < NUM_COLS; k++) begin
         for (int g = 0; g < NUM_GRPS; g++) begin
            col_in[k] = col_in[k] + COL_W'(grp_ff[k][g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && in_valid) begin
         pp_ff   <= pp_in;
         neg3_ff <= in_neg;
      end
      if (adv4 && v3_ff) begin
         grp_ff  <= grp_in;
         neg4_ff <= neg3_ff;
      end
      if (adv5 && v4_ff) begin
         col_ff  <= col_in;
         neg5_ff <= neg4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_cols  = col_ff;
   assign out_neg   = neg5_ff;

endmodule

// ===== rtl/core/fpm_accum.sv =====
module fpm_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  fpm_pkg::col_vec_type in_cols,
   input  logic                 in_neg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fpm_pkg::word_type    out_result
);
   import fpm_pkg::*;

   localparam logic [COL_W:0] RND_HALF = (COL_W + 1)'(1) << RND_BIT;

   logic v6_ff, v7_ff, v8_ff;
   logic adv6, adv7, adv8;

   logic [COL_W:0]      rnd0, rnd1;
   logic [RND_W-1:0]    acc1, acc2;
   logic [COL_HI_W-1:0] hi;
   word_type            lo_vec, h1_vec, h2_vec;
   word_type            sum_ff, sum_in, cy_ff, cy_in;
   word_type            res_ff, res_in;
   word_type            out_ff, out_in;
   logic                neg6_ff, neg7_ff;

   assign adv8     = !v8_ff || out_ready;
   assign adv7     = !v7_ff || adv8;
   assign adv6     = !v6_ff || adv7;
   assign in_ready = adv6;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (adv6) v6_ff <= in_valid;
         if (adv7) v7_ff <= v6_ff;
         if (adv8) v8_ff <= v7_ff;
      end
   end

   // Round the two lowest columns in turn, then lay every column out as three
   // non-overlapping vectors (low limb, next limb, top bits) and compress.
   always_comb begin
      lo_vec = '0;
      h1_vec = '0;
      h2_vec = '0;
      hi     = '0;
      rnd0   = {1'b0, in_cols[0]} + RND_HALF;
      acc1   = rnd0[LIMB_W +: RND_W];
      rnd1   = (COL_W + 1)'(acc1) + {1'b0, in_cols[1]} + RND_HALF;
      acc2   = rnd1[LIMB_W +: RND_W];
      h2_vec[RND_W-1:0] = acc2;
      for (int m = 0; m < NUM_LIMBS; m++) begin
         lo_vec[LIMB_W*m +: LIMB_W] = in_cols[m+ROUND_COLS][LIMB_W-1:0];
         hi = in_cols[m+ROUND_COLS][COL_W-1:LIMB_W];
         if (m + 1 < NUM_LIMBS) begin
            h1_vec[LIMB_W*(m+1) +: LIMB_W] = hi[LIMB_W-1:0];
         end
         if (m + 2 < NUM_LIMBS) begin
            h2_vec[LIMB_W*(m+2) +: COL_TOP_W] = hi[COL_HI_W-1:LIMB_W];
         end
      end
      sum_in = lo_vec ^ h1_vec ^ h2_vec;
      cy_in  = ((lo_vec & h1_vec) | (lo_vec & h2_vec) | (h1_vec & h2_vec)) << 1;
   end

   assign res_in = sum_ff + cy_ff;
   assign out_in = neg7_ff ? neg_word(res_ff) : res_ff;

   always_ff @(posedge clock) begin
      if (adv6 && in_valid) begin
         sum_ff  <= sum_in;
         cy_ff   <= cy_in;
         neg6_ff <= in_neg;
      end
      if (adv7 && v6_ff) begin
         res_ff  <= res_in;
         neg7_ff <= neg6_ff;
      end
      if (adv8 && v7_ff) begin
         out_ff  <= out_in;
      end
   end

   assign out_valid  = v8_ff;
   assign out_result = out_ff;

endmodule

// ===== rtl/core/fixed_point_multiply_256_top.sv =====
// Channel   Direction  Ports                      Payload
// req       in         req_tvalid/tready/tdata    a (255:0), b (511:256)
//                      req_tuser                  op: 1 squares a
// rsp       out        rsp_tvalid/tready/tdata    product (255:0)
//
// One item per cycle sustained while rsp_tready is high, through eight register
// stages (two magnitude stages, three product and column-tree stages, compress,
// carry-propagate add, sign stage). Reset is synchronous, active high, and
// clears only the stage valid bits. Each stage holds while the one after it is
// full and stalled; a bubble is filled at once, so req_tready falls only when
// all eight stages hold items and rsp_tready is low.
module fixed_point_multiply_256_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3 (64 bits each)
   input  logic [fpm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // op
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // r_w0, r_w1, r_w2, r_w3 (64 bits each)
   output logic [fpm_pkg::WORD_W-1:0]          rsp_tdata
);
   import fpm_pkg::*;

   // Magnitude section to product section
   logic        mag_valid, mag_ready, mag_neg;
   word_type    mag_a, mag_b;

   // Product section to accumulation section
   logic        col_valid, col_ready, col_neg;
   col_vec_type cols;

   // Strip signs, select the second operand
   fpm_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_square (req_tuser),
      .in_a      (req_tdata[WORD_W-1:0]),
      .in_b      (req_tdata[REQ_DATA_W-1:WORD_W]),
      .out_valid (mag_valid),
      .out_ready (mag_ready),
      .out_mag_a (mag_a),
      .out_mag_b (mag_b),
      .out_neg   (mag_neg)
   );

   // Limb products and registered column sums
   fpm_ppgen u_ppgen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mag_valid),
      .in_ready  (mag_ready),
      .in_mag_a  (mag_a),
      .in_mag_b  (mag_b),
      .in_neg    (mag_neg),
      .out_valid (col_valid),
      .out_ready (col_ready),
      .out_cols  (cols),
      .out_neg   (col_neg)
   );

   // Round, carry-propagate, reapply the sign, hold the result
   fpm_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (col_valid),
      .in_ready   (col_ready),
      .in_cols    (cols),
      .in_neg     (col_neg),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_tdata)
   );

endmodule

// ===== rtl/core/fpm_checker.sv =====
module fpm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [fpm_pkg::WORD_W-1:0] rsp_tdata
);
   import fpm_pkg::*;

   logic [DEPTH_W-1:0] cnt_ff, cnt_in;
   logic               req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Track items in flight
   always_comb begin
      cnt_in = cnt_ff;
      if (req_acc && !rsp_acc) cnt_in = cnt_ff + DEPTH_W'(1);
      if (rsp_acc && !req_acc) cnt_in = cnt_ff - DEPTH_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != '0)
      else $error("result shown with no item in flight");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_W'(PIPE_DEPTH))
      else $error("more items in flight than stages");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == DEPTH_W'(PIPE_DEPTH) && !rsp_tready |-> !req_tready)
      else $error("item taken while every stage is full and stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

endmodule

bind fixed_point_multiply_256_top fpm_checker u_fpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/fixed_point_multiply_256_top_tb.sv =====
`timescale 1ns / 1ps

module fixed_point_multiply_256_top_tb;

   import fpm_pkg::word_type;

   // Operation codes carried on req_tuser
   localparam logic OP_MULTIPLY = 1'b0;
   localparam logic OP_SQUARE   = 1'b1;

   // Landmark Q64.192 values
   localparam word_type FX_ZERO      = '0;
   localparam word_type FX_LSB       = 256'd1;
   localparam word_type FX_ONE       = {64'd1, 192'd0};
   localparam word_type FX_MINUS_ONE = {64'hFFFF_FFFF_FFFF_FFFF, 192'd0};
   localparam word_type FX_MOST_NEG  = {1'b1, 255'd0};
   localparam word_type FX_MAX_POS   = {1'b0, {255{1'b1}}};
   localparam word_type FX_ALL_ONES  = {256{1'b1}};

   localparam int RANDOM_ITEMS = 1600;
   localparam int TAIL_ITEMS   = 150;   // no idling while the last items go through

   typedef struct packed {
      logic     op;
      word_type a;
      word_type b;
   } mul_item_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3 (64 bits each)
   logic [fpm_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   // op
   logic                               req_tuser  = OP_MULTIPLY;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // r_w0, r_w1, r_w2, r_w3 (64 bits each)
   logic [fpm_pkg::WORD_W-1:0]         rsp_tdata;

   mul_item_type pending_items[$];
   word_type     products_due[$];

   int items_total    = 0;
   int items_accepted = 0;
   int products_seen  = 0;
   int square_items   = 0;
   int negative_items = 0;
   int mismatches     = 0;

   int req_gap        = 0;
   int req_gap_odds   = 0;
   int rsp_stall      = 0;
   int rsp_stall_odds = 0;
   int rsp_cycles     = 0;

   wire quiet_tail = (items_accepted + TAIL_ITEMS >= items_total);

   fixed_point_multiply_256_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Product of two Q64.192 numbers: magnitudes in 16-bit limbs, columns 10 and 11
   // rounded on bit 15, columns 12 to 27 kept, sign applied modulo 2^256.
   function automatic word_type q64_product(input logic op, input word_type a,
                                            input word_type b);
      word_type    x;
      word_type    y;
      word_type    r;
      logic        negate;
      logic [63:0] acc;
      logic [63:0] col_sum;
      int          c;
      int          i;
      int          j;
      x      = a;
      y      = (op == OP_SQUARE) ? a : b;
      negate = 1'b0;
      if (x[255]) begin
         x      = ~x + 256'd1;
         negate = ~negate;
      end
      if (y[255]) begin
         y      = ~y + 256'd1;
         negate = ~negate;
      end
      acc = '0;
      r   = '0;
      for (c = 10; c <= 27; c++) begin
         col_sum = '0;
         for (i = 0; i < 16; i++) begin
            j = c - i;
            if (j >= 0 && j < 16) begin
               col_sum += 64'(x[16*i +: 16]) * 64'(y[16*j +: 16]);
            end
         end
         acc += col_sum;
         if (c < 12) begin
            acc = (acc >> 16) + 64'(acc[15]);
         end else begin
            r[16*(c-12) +: 16] = acc[15:0];
            acc = acc >> 16;
         end
      end
      if (negate) begin
         r = ~r + 256'd1;
      end
      return r;
   endfunction

   function automatic word_type rand_word();
      word_type w;
      int       k;
      for (k = 0; k < 8; k++) begin
         w[32*k +: 32] = $urandom;
      end
      return w;
   endfunction

   // Mix full-range values with small, sparse, sign-extended and landmark ones
   function automatic word_type rand_operand();
      word_type w;
      int       k;
      w = rand_word();
      case ($urandom_range(0, 9))
         4, 5: begin
            w[255:192] = 64'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1) begin
               w[255:192] = ~w[255:192];
            end
         end
         6: begin
            case ($urandom_range(0, 6))
               0: w = FX_ZERO;
               1: w = FX_ONE;
               2: w = FX_MINUS_ONE;
               3: w = FX_MOST_NEG;
               4: w = FX_MAX_POS;
               5: w = FX_LSB;
               default: w = FX_ALL_ONES;
            endcase
         end
         7: begin
            w = FX_LSB << $urandom_range(0, 255);
            if ($urandom_range(0, 1) == 1) begin
               w = ~w + 256'd1;
            end
         end
         8: begin
            w = word_type'($signed(w) >>> $urandom_range(0, 255));
         end
         9: begin
            for (k = 0; k < 16; k++) begin
               case ($urandom_range(0, 2))
                  0: w[16*k +: 16] = 16'h0000;
                  1: w[16*k +: 16] = 16'hFFFF;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic int pick_odds(input int scale);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return scale;
         2: return 4 * scale;
         default: return 10 * scale;
      endcase
   endfunction

   task automatic add_item(input logic op, input word_type a, input word_type b);
      mul_item_type it;
      it.op = op;
      it.a  = a;
      it.b  = b;
      pending_items.push_back(it);
      if (op == OP_SQUARE) begin
         square_items++;
      end
      if (a[255] || (op == OP_MULTIPLY && b[255])) begin
         negative_items++;
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // Driver: present the next pending item, with random bursts of idle cycles
   always @(posedge clock) begin
      mul_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            products_due.push_back(q64_product(req_tuser, req_tdata[255:0],
                                               req_tdata[511:256]));
            items_accepted++;
            if (items_accepted % 64 == 0) begin
               req_gap_odds = pick_odds(5);
            end
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0 || pending_items.size() == 0) begin
               if (req_gap > 0) begin
                  req_gap--;
               end
               req_tvalid <= 1'b0;
            end else begin
               nxt = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.b, nxt.a};
               req_tuser  <= nxt.op;
               if (!quiet_tail && $urandom_range(0, 99) < req_gap_odds) begin
                  req_gap = $urandom_range(1, 13);
               end
            end
         end
      end
   end

   // Monitor: check each product against the oldest one due, stall at random
   always @(posedge clock) begin
      word_type want;
      int       k;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            products_seen++;
            if (products_due.size() == 0) begin
               note_mismatch($sformatf("product %h with nothing due", rsp_tdata));
            end else begin
               want = products_due.pop_front();
               for (k = 0; k < 4; k++) begin
                  if (rsp_tdata[64*k +: 64] !== want[64*k +: 64]) begin
                     note_mismatch($sformatf("product %0d r_w%0d got %h want %h",
                                             products_seen, k,
                                             rsp_tdata[64*k +: 64], want[64*k +: 64]));
                  end
               end
            end
         end
         rsp_cycles++;
         if (rsp_cycles % 97 == 0) begin
            rsp_stall_odds = pick_odds(3);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 99) < rsp_stall_odds) begin
               rsp_stall = $urandom_range(1, 13);
            end
         end
      end
   end

   initial begin
      int n;
      // Landmarks, overflow, the most negative value and sign handling
      add_item(OP_MULTIPLY, FX_ZERO, FX_ZERO);
      add_item(OP_MULTIPLY, FX_MAX_POS, FX_MAX_POS);
      add_item(OP_MULTIPLY, FX_MOST_NEG, FX_ONE);
      add_item(OP_MULTIPLY, FX_MOST_NEG, FX_MOST_NEG);
      add_item(OP_MULTIPLY, FX_MOST_NEG, FX_MINUS_ONE);
      add_item(OP_MULTIPLY, FX_ALL_ONES, FX_ALL_ONES);
      add_item(OP_MULTIPLY, FX_ONE, rand_word());
      add_item(OP_MULTIPLY, FX_MINUS_ONE, FX_MAX_POS);
      add_item(OP_MULTIPLY, FX_MINUS_ONE, FX_MINUS_ONE);
      add_item(OP_MULTIPLY, FX_MAX_POS, FX_MINUS_ONE);
      add_item(OP_MULTIPLY, {64'd3, 2'b01, 190'd0}, ~{64'd2, 1'b1, 191'd0} + 256'd1);
      // Rounding: exactly half an LSB, a quarter of an LSB, and a column-10 carry
      add_item(OP_MULTIPLY, FX_LSB << 96, FX_LSB << 95);
      add_item(OP_MULTIPLY, FX_LSB << 96, FX_LSB << 94);
      add_item(OP_MULTIPLY, ~(FX_LSB << 96) + 256'd1, FX_LSB << 95);
      add_item(OP_MULTIPLY, 256'hFFFF << 80, 256'hFFFF << 80);
      // Low limbs only reach the columns that are never formed
      add_item(OP_MULTIPLY, {176'd0, {80{1'b1}}}, {176'd0, {80{1'b1}}});
      // Squares ignore b and never negate
      add_item(OP_SQUARE, ~{64'd1, 1'b1, 191'd0} + 256'd1, rand_word());
      add_item(OP_SQUARE, FX_MOST_NEG, FX_ZERO);
      add_item(OP_SQUARE, FX_MAX_POS, FX_MOST_NEG);
      add_item(OP_SQUARE, {64'd2, 192'd0}, FX_ALL_ONES);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         add_item(($urandom_range(0, 3) == 0) ? OP_SQUARE : OP_MULTIPLY,
                  rand_operand(), rand_operand());
      end
      items_total = pending_items.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (!(items_accepted == items_total && products_due.size() == 0)) begin
         @(posedge clock);
      end
      // Let any stray product surface
      repeat (4 * fpm_pkg::PIPE_DEPTH) @(posedge clock);

      $display("Checked %0d products of %0d items: %0d squares, %0d with a negative operand,",
               products_seen, items_total, square_items, negative_items);
      $display("with random idling on both channels and a final stretch at full rate.");
      if (mismatches == 0) begin
         $display("[fixed_point_multiply_256_top] OK");
      end else begin
         $display("[fixed_point_multiply_256_top] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d of %0d items accepted", items_accepted, items_total);
      $display("[fixed_point_multiply_256_top] ERROR");
      $finish;
   end

endmodule
